// ===== rtl/core/vector_angle_degrees_defines.svh =====
// assertion macros for the vector angle core
`ifndef VECTOR_ANGLE_DEGREES_DEFINES_SVH
`define VECTOR_ANGLE_DEGREES_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector angle check failed");

// next-cycle implication, checked outside reset
`define VAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector angle check failed");

`endif

// ===== rtl/core/vad_pkg.sv =====
// shared types, constants and step table for the vector angle core
`timescale 1ns / 1ps

package vad_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int ITERATIONS_DEF = 16;

    localparam int CORE_W   = 64;
    localparam int ANG_FRAC = 16;
    localparam int ZW       = 25;
    localparam int FULL_W   = 26;
    localparam int STEP_W   = 5;

    localparam logic [FULL_W-1:0] DEG90  = FULL_W'(90 << ANG_FRAC);
    localparam logic [FULL_W-1:0] DEG180 = FULL_W'(180 << ANG_FRAC);
    localparam logic [FULL_W-1:0] DEG270 = FULL_W'(270 << ANG_FRAC);
    localparam logic [FULL_W-1:0] DEG360 = FULL_W'(360 << ANG_FRAC);

    typedef enum logic [2:0] {
        KIND_AXIS_0,
        KIND_AXIS_90,
        KIND_AXIS_180,
        KIND_AXIS_270,
        KIND_Q1,
        KIND_Q2,
        KIND_Q3,
        KIND_Q4
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic signed [CORE_W-1:0] x;
        logic signed [CORE_W-1:0] y;
        logic signed [ZW-1:0]     z;
    } cordic_t;

    // atan(2^-i) in degrees, 16 fractional bits
    function automatic logic signed [ZW-1:0] step_angle(input logic [STEP_W-1:0] idx);
        logic signed [ZW-1:0] val;
        unique case (idx)
            5'd0:    val = ZW'(2949120);
            5'd1:    val = ZW'(1740967);
            5'd2:    val = ZW'(919879);
            5'd3:    val = ZW'(466945);
            5'd4:    val = ZW'(234379);
            5'd5:    val = ZW'(117304);
            5'd6:    val = ZW'(58666);
            5'd7:    val = ZW'(29335);
            5'd8:    val = ZW'(14668);
            5'd9:    val = ZW'(7334);
            5'd10:   val = ZW'(3667);
            5'd11:   val = ZW'(1833);
            5'd12:   val = ZW'(917);
            5'd13:   val = ZW'(458);
            5'd14:   val = ZW'(229);
            5'd15:   val = ZW'(115);
            5'd16:   val = ZW'(57);
            5'd17:   val = ZW'(29);
            5'd18:   val = ZW'(14);
            5'd19:   val = ZW'(7);
            5'd20:   val = ZW'(4);
            5'd21:   val = ZW'(2);
            5'd22:   val = ZW'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/vad_cordic_stage.sv =====
// one registered cordic vectoring iteration
`timescale 1ns / 1ps

module vad_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             load,
    input  vad_pkg::cordic_t prev,
    output vad_pkg::cordic_t stage
);
    import vad_pkg::*;

    localparam logic [STEP_W-1:0] SHIFT = STEP_W'(STEP);
    localparam logic signed [ZW-1:0] ANGLE = step_angle(SHIFT);

    cordic_t data_reg;
    cordic_t data_next;

    logic signed [CORE_W-1:0] dx;
    logic signed [CORE_W-1:0] dy;

    always_comb
    begin
        dx = prev.y >>> SHIFT;
        dy = prev.x >>> SHIFT;
        data_next.kind = prev.kind;
        if (!prev.y[CORE_W-1])
        begin
            data_next.x = prev.x + dx;
            data_next.y = prev.y - dy;
            data_next.z = prev.z + ANGLE;
        end
        else
        begin
            data_next.x = prev.x - dx;
            data_next.y = prev.y + dy;
            data_next.z = prev.z - ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign stage = data_reg;

endmodule

// ===== rtl/core/vector_angle_degrees.sv =====
// top level: direction of a screen vector in degrees, pipelined cordic
`timescale 1ns / 1ps
`include "vector_angle_degrees_defines.svh"

// channel   dir  tdata (lowest bit first)          handshake
// s_axis    in   x_coord, y_coord                  tvalid / tready
// m_axis    out  angle_q8                          tvalid / tready
//
// one request per cycle sustained while the output is not stalled
// stages: input fold, one per cordic iteration, quadrant combine, rounding
// the depth is set by the chain of cordic iterations, one register each
// rst_n clears the stage valid bits only, payload registers are not reset
// a stalled output holds; empty stages ahead of it keep filling

module vector_angle_degrees #(
    parameter int COORD_BITS = vad_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = vad_pkg::FRAC_BITS_DEF,
    parameter int ITERATIONS = vad_pkg::ITERATIONS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // x_coord, y_coord
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // angle_q8
    output logic [((9+FRAC_BITS+7)/8)*8-1:0]     m_axis_tdata
);
    import vad_pkg::*;

    localparam int GUARD    = 61 - COORD_BITS;
    localparam int OUT_W    = 9 + FRAC_BITS;
    localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int NSTG     = ITERATIONS + 3;
    localparam int SH       = ANG_FRAC - FRAC_BITS;
    localparam int SUM_W    = FULL_W + 1;
    localparam logic [SUM_W-1:0] ROUND_ADD = (SUM_W'(1) << SH) >> 1;
    localparam logic [OUT_W-1:0] TURN = OUT_W'(360 << FRAC_BITS);

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] rdy;

    cordic_t stage_data [ITERATIONS+1];
    cordic_t entry_reg;
    cordic_t entry_next;

    logic [FULL_W-1:0] full_reg;
    logic [FULL_W-1:0] full_next;
    logic [OUT_W-1:0]  angle_reg;
    logic [OUT_W-1:0]  angle_next;

    logic signed [COORD_BITS-1:0] xs;
    logic signed [COORD_BITS-1:0] ys;
    logic signed [COORD_BITS:0]   xe;
    logic signed [COORD_BITS:0]   ye;
    logic [COORD_BITS:0]          ax;
    logic [COORD_BITS:0]          ay;
    logic signed [ZW-1:0]         zc;
    logic [FULL_W-1:0]            a;
    logic [SUM_W-1:0]             rsum;
    logic [OUT_W-1:0]             rval;

    // stall control: a stage moves when the output is ready or any stage at or after it has room
    for (genvar k = 0; k < NSTG; k++)
    begin : g_rdy
        assign rdy[k] = m_axis_tready || !(&valid_reg[NSTG-1:k]);
    end

    assign valid_next = (rdy & {valid_reg[NSTG-2:0], s_axis_tvalid})
                      | (~rdy & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // input fold to first quadrant
    always_comb
    begin
        xs = s_axis_tdata[COORD_BITS-1:0];
        ys = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        xe = {xs[COORD_BITS-1], xs};
        ye = {ys[COORD_BITS-1], ys};
        ax = xe[COORD_BITS] ? (COORD_BITS+1)'(-xe) : (COORD_BITS+1)'(xe);
        ay = ye[COORD_BITS] ? (COORD_BITS+1)'(-ye) : (COORD_BITS+1)'(ye);
        entry_next.x = CORE_W'(ax) << GUARD;
        entry_next.y = CORE_W'(ay) << GUARD;
        entry_next.z = '0;
        priority if (xs == '0 && ys == '0)
            entry_next.kind = KIND_AXIS_0;
        else if (xs == '0)
            entry_next.kind = ys[COORD_BITS-1] ? KIND_AXIS_90 : KIND_AXIS_270;
        else if (ys == '0)
            entry_next.kind = xs[COORD_BITS-1] ? KIND_AXIS_180 : KIND_AXIS_0;
        else if (!xs[COORD_BITS-1] && ys[COORD_BITS-1])
            entry_next.kind = KIND_Q1;
        else if (xs[COORD_BITS-1] && ys[COORD_BITS-1])
            entry_next.kind = KIND_Q2;
        else if (xs[COORD_BITS-1])
            entry_next.kind = KIND_Q3;
        else
            entry_next.kind = KIND_Q4;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            entry_reg <= entry_next;
        end
    end

    assign stage_data[0] = entry_reg;

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_iter
        vad_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk   (clk),
            .load  (rdy[i+1]),
            .prev  (stage_data[i]),
            .stage (stage_data[i+1])
        );
    end

    // clamp and quadrant combine
    always_comb
    begin
        zc = stage_data[ITERATIONS].z;
        if (zc[ZW-1])
            a = '0;
        else if (zc > $signed({1'b0, DEG90[ZW-2:0]}))
            a = DEG90;
        else
            a = FULL_W'(zc[ZW-2:0]);
        unique case (stage_data[ITERATIONS].kind)
            KIND_AXIS_0:   full_next = '0;
            KIND_AXIS_90:  full_next = DEG90;
            KIND_AXIS_180: full_next = DEG180;
            KIND_AXIS_270: full_next = DEG270;
            KIND_Q1:       full_next = a;
            KIND_Q2:       full_next = DEG180 - a;
            KIND_Q3:       full_next = DEG180 + a;
            KIND_Q4:       full_next = DEG360 - a;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ITERATIONS+1])
        begin
            full_reg <= full_next;
        end
    end

    // round half up and wrap a full turn
    always_comb
    begin
        rsum = {1'b0, full_reg} + ROUND_ADD;
        rval = OUT_W'(rsum >> SH);
        angle_next = (rval >= TURN) ? rval - TURN : rval;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NSTG-1])
        begin
            angle_reg <= angle_next;
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = valid_reg[NSTG-1];
    assign m_axis_tdata  = M_DATA_W'(angle_reg);

    `VAD_ASSERT_NOW(a_angle_below_turn, clk, rst_n, m_axis_tvalid, angle_reg < TURN)
    `VAD_ASSERT_NEXT(a_entry_held, clk, rst_n, valid_reg[0] && !rdy[1], valid_reg[0])
    `VAD_ASSERT_NEXT(a_zero_vector, clk, rst_n,
        s_axis_tvalid && s_axis_tready && xs == '0 && ys == '0,
        entry_reg.kind == KIND_AXIS_0)

endmodule
